/* sv/rfc_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the response frame checker.
// No dependencies; imported by every module of the checker.
`default_nettype none

package rfc_pkg;

  // Default largest frame, header bytes included
  localparam int RFC_MAX_FRAME = 2048;

  // Frame layout and CRC-16/CCITT-FALSE constants
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam int          HEADER_LEN = 6;
  localparam logic [7:0]  ACK_RESET  = 8'h01;

  // Total length L + 6 needs 17 bits; reported length is 12 bits
  localparam int TOT_W = 17;
  localparam int LEN_W = 12;

  // Configuration register indexes
  localparam logic REG_ACK_VALUE = 1'b0;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [1:0] {
    ST_SUCCESS = 2'd0,
    ST_FAIL    = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_FORMAT  = 2'd3
  } status_t;

  // One result item plus its request flag
  typedef struct packed {
    logic             emit;
    logic             kind;
    logic [7:0]       data;
    status_t          status;
    logic [LEN_W-1:0] length;
  } res_t;

  // One byte through the MSB-first CRC-16, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/rfc_frame.sv */
// Frame tracker: byte counter, length field, running CRC and the end-of-frame verdict.
// Depends on rfc_pkg.
`default_nettype none

module rfc_frame
  import rfc_pkg::*;
#(
  parameter int MAX_FRAME = RFC_MAX_FRAME
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] rx_byte,
  input  wire logic       abort,
  input  wire logic [7:0] ack_value,
  output res_t            res
);

  localparam int CNT_W = $clog2(MAX_FRAME);
  localparam logic [TOT_W-1:0] MaxTot = TOT_W'(MAX_FRAME);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             crc_hi_r, crc_hi_nxt;
  logic             ack_ok_r, ack_ok_nxt;
  logic             first_zero_r, first_zero_nxt;

  logic [15:0]      crc_upd;
  logic [15:0]      len_hdr;
  logic [TOT_W-1:0] idx_ext, total, total_hdr;
  logic [31:0]      cnt_wide, tot_wide;
  logic             first_zero_now, crc_ok, clear;

  assign crc_upd   = crc16_byte(crc_r, rx_byte);
  assign idx_ext   = TOT_W'(cnt_r);
  assign total     = TOT_W'(len_r) + TOT_W'(HEADER_LEN);
  assign len_hdr   = {len_r[15:8], rx_byte};
  assign total_hdr = TOT_W'(len_hdr) + TOT_W'(HEADER_LEN);
  assign cnt_wide  = 32'(cnt_r);
  assign tot_wide  = 32'(total);
  assign first_zero_now = (cnt_r == '0) ? (rx_byte == 8'h00) : first_zero_r;
  assign crc_ok    = crc_hi_r && (rx_byte == crc_r[7:0]);

  // Per-byte decode: state update and result
  always_comb begin
    cnt_nxt        = cnt_r + 1'b1;
    len_nxt        = len_r;
    crc_nxt        = crc_r;
    crc_hi_nxt     = crc_hi_r;
    ack_ok_nxt     = ack_ok_r;
    first_zero_nxt = first_zero_now;
    clear          = 1'b0;
    res            = '0;
    res.kind       = KIND_STATUS;

    priority if (abort) begin
      res.emit   = 1'b1;
      res.status = ST_TIMEOUT;
      res.length = cnt_wide[LEN_W-1:0];
      clear      = 1'b1;
    end else if (idx_ext < TOT_W'(HEADER_LEN)) begin
      // Header bytes
      crc_nxt = crc_upd;
      if (idx_ext == TOT_W'(4)) begin
        len_nxt = {rx_byte, 8'h00};
      end
      if (idx_ext == TOT_W'(5)) begin
        len_nxt = len_hdr;
        if ((len_hdr < 16'd3) || (total_hdr > MaxTot)) begin
          res.emit   = 1'b1;
          res.status = first_zero_now ? ST_TIMEOUT : ST_FORMAT;
          res.length = LEN_W'(HEADER_LEN);
          clear      = 1'b1;
        end
      end
    end else if ((idx_ext + TOT_W'(3)) < total) begin
      // Payload byte
      crc_nxt    = crc_upd;
      res.emit   = 1'b1;
      res.kind   = KIND_PAYLOAD;
      res.data   = rx_byte;
      res.status = ST_SUCCESS;
    end else if ((idx_ext + TOT_W'(3)) == total) begin
      // Acknowledge byte
      crc_nxt    = crc_upd;
      ack_ok_nxt = (rx_byte == ack_value);
    end else if ((idx_ext + TOT_W'(2)) == total) begin
      // CRC high byte
      crc_hi_nxt = (rx_byte == crc_r[15:8]);
    end else begin
      // CRC low byte ends the frame
      res.emit = 1'b1;
      if (first_zero_r) begin
        res.status = ST_TIMEOUT;
      end else if (!crc_ok || !ack_ok_r) begin
        res.status = ST_FAIL;
      end else begin
        res.status = ST_SUCCESS;
      end
      res.length = tot_wide[LEN_W-1:0];
      clear      = 1'b1;
    end

    if (clear) begin
      cnt_nxt        = '0;
      len_nxt        = '0;
      crc_nxt        = CRC_INIT;
      crc_hi_nxt     = 1'b0;
      ack_ok_nxt     = 1'b0;
      first_zero_nxt = 1'b0;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      len_r        <= '0;
      crc_r        <= CRC_INIT;
      crc_hi_r     <= 1'b0;
      ack_ok_r     <= 1'b0;
      first_zero_r <= 1'b0;
    end else if (fire) begin
      cnt_r        <= cnt_nxt;
      len_r        <= len_nxt;
      crc_r        <= crc_nxt;
      crc_hi_r     <= crc_hi_nxt;
      ack_ok_r     <= ack_ok_nxt;
      first_zero_r <= first_zero_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/rfc_out.sv */
// Result register of the frame checker: holds one result until the consumer takes it.
// Depends on rfc_pkg.
`default_nettype none

module rfc_out
  import rfc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire res_t             res,
  input  wire logic             out_stall,
  output logic                  hold,
  output logic                  out_valid,
  output logic                  out_kind,
  output logic [7:0]            out_byte,
  output logic [1:0]            out_frame_status,
  output logic [LEN_W-1:0]      out_frame_length
);

  logic   valid_r, valid_nxt;
  res_t   res_r;

  // Full and not drained this cycle
  assign hold = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (load && res.emit) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = res_r.kind;
  assign out_byte         = res_r.data;
  assign out_frame_status = res_r.status;
  assign out_frame_length = res_r.length;

endmodule

`default_nettype wire

/* sv/response_frame_checker_crc16_core.sv */
// Top level of the response frame checker: input register, ack register port,
// frame tracker and result register. Depends on rfc_pkg, rfc_frame and rfc_out.
//
// Takes one received frame byte per clock and, with no stall at the output, keeps
// that rate indefinitely: each byte is held in the input register, and its result
// (a payload byte or the end-of-frame status) is then registered in the result
// register. The CRC-16/CCITT-FALSE byte update and the position compares sit in
// one stage between the input register and the result register.
// Bytes 4 and 5 give the big-endian length L; the frame is L + 6 bytes, and bytes
// 6 to L+2 come out as payload. The ack register (byte address 0, reset 0x01) is
// compared with byte L+3; write it only while the checker is idle.
`default_nettype none

module response_frame_checker_crc16_core
  import rfc_pkg::*;
#(
  parameter int MAX_FRAME = RFC_MAX_FRAME
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Input channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_rx_byte,
  input  wire logic             in_abort,
  // Result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_kind,
  output logic [7:0]            out_byte,
  output logic [1:0]            out_frame_status,
  output logic [LEN_W-1:0]      out_frame_length,
  // Configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_abort_r;
  logic [7:0] ack_r;
  logic       hold, fire;
  res_t       res;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACK_VALUE) ? {24'h000000, ack_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_r <= ACK_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ACK_VALUE)) begin
      ack_r <= pwdata[7:0];
    end
  end

  // Input register: moves on unless the result register is held
  assign fire     = s1_valid_r && !hold;
  assign in_stall = s1_valid_r && hold;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_rx_byte;
      s1_abort_r <= in_abort;
    end
  end

  rfc_frame #(
    .MAX_FRAME(MAX_FRAME)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .rx_byte  (s1_byte_r),
    .abort    (s1_abort_r),
    .ack_value(ack_r),
    .res      (res)
  );

  rfc_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (fire),
    .res             (res),
    .out_stall       (out_stall),
    .hold            (hold),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_frame_status(out_frame_status),
    .out_frame_length(out_frame_length)
  );

endmodule

`default_nettype wire

/* sim/response_frame_checker_crc16_core_test.sv */
// Self-checking bench for the response frame checker: random and directed frames,
// CRC-16 prediction, random idling and a long output hold-off.
// Depends on rfc_pkg and response_frame_checker_crc16_core.
`timescale 1ns / 100ps

module response_frame_checker_crc16_core_test;
  import rfc_pkg::*;

  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 400;
  localparam int PRESSURE_PHASE = 4;
  localparam int PHASE_ITEMS    = 165;

  typedef enum {FL_NONE, FL_CRC_HI, FL_CRC_LO, FL_ACK, FL_ABORT} flaw_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       ab;
  } frame_req_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    status_t          status;
    logic [LEN_W-1:0] length;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             in_abort = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_kind;
  logic [7:0]       out_byte;
  logic [1:0]       out_frame_status;
  logic [LEN_W-1:0] out_frame_length;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = 3'd0;
  logic [31:0]      pwdata = 32'd0;
  logic [31:0]      prdata;
  logic             pready;

  response_frame_checker_crc16_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_abort         (in_abort),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_frame_status (out_frame_status),
    .out_frame_length (out_frame_length),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Requests waiting to be driven and results still owed by the block
  frame_req_t    pending_bytes[$];
  frame_result_t expected_results[$];

  // Bench copy of the frame tracker state
  int unsigned rx_count  = 0;
  logic [15:0] len_field = 16'h0000;
  logic [15:0] run_crc   = CRC_INIT;
  bit          hi_match  = 1'b0;
  bit          ack_match = 1'b0;
  bit          lead_zero = 1'b0;
  logic [7:0]  ack_cfg   = ACK_RESET;

  int mismatches = 0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int phase_id   = 0;
  int queued     = 0;
  int hold_cnt   = 0;
  bit hold_done  = 1'b0;

  frame_req_t    next_req;
  frame_result_t pred;
  frame_result_t want;

  // MSB-first CRC-16, polynomial 0x1021
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    return c;
  endfunction

  // Status item; the frame state goes back to its reset value
  function automatic bit close_frame(input status_t s, input int unsigned n,
                                     output frame_result_t r);
    r.kind    = KIND_STATUS;
    r.data    = 8'h00;
    r.status  = s;
    r.length  = n[LEN_W-1:0];
    rx_count  = 0;
    len_field = 16'h0000;
    run_crc   = CRC_INIT;
    hi_match  = 1'b0;
    ack_match = 1'b0;
    lead_zero = 1'b0;
    return 1'b1;
  endfunction

  // Advance the tracker by one request; returns 1 when a result is due
  function automatic bit track_byte(input logic [7:0] b, input logic ab,
                                    output frame_result_t r);
    int unsigned idx;
    int unsigned total;
    bit          crc_good;
    idx = rx_count;
    r = '0;
    if (ab) return close_frame(ST_TIMEOUT, rx_count, r);
    // header: lead byte, length, CRC
    if (idx < HEADER_LEN) begin
      if (idx == 0) lead_zero = (b == 8'h00);
      if (idx == 4) len_field = {b, 8'h00};
      if (idx == 5) len_field[7:0] = b;
      run_crc  = crc_next(run_crc, b);
      rx_count = idx + 1;
      if (idx == 5) begin
        total = len_field + HEADER_LEN;
        if (len_field < 3 || total > RFC_MAX_FRAME)
          return close_frame(lead_zero ? ST_TIMEOUT : ST_FORMAT, HEADER_LEN, r);
      end
      return 1'b0;
    end
    total    = len_field + HEADER_LEN;
    rx_count = idx + 1;
    if (idx + 3 < total) begin
      run_crc = crc_next(run_crc, b);
      r.kind  = KIND_PAYLOAD;
      r.data  = b;
      return 1'b1;
    end
    if (idx + 3 == total) begin
      run_crc   = crc_next(run_crc, b);
      ack_match = (b == ack_cfg);
      return 1'b0;
    end
    if (idx + 2 == total) begin
      hi_match = (b == run_crc[15:8]);
      return 1'b0;
    end
    crc_good = hi_match && (b == run_crc[7:0]);
    return close_frame(lead_zero ? ST_TIMEOUT :
                       (!crc_good || !ack_match) ? ST_FAIL : ST_SUCCESS, total, r);
  endfunction

  // Build one frame of length field len, optionally damaged, into the request queue
  task automatic queue_frame(input int unsigned len, input bit zero_lead, input flaw_t flaw);
    logic [7:0]  fb[$];
    logic [15:0] c;
    int unsigned total;
    int unsigned cut;
    fb.push_back(zero_lead ? 8'h00 : 8'($urandom_range(255, 1)));
    repeat (3) fb.push_back(8'($urandom));
    fb.push_back(len[15:8]);
    fb.push_back(len[7:0]);
    total = len + HEADER_LEN;
    if (len >= 3 && total <= RFC_MAX_FRAME) begin
      repeat (len - 3) fb.push_back(8'($urandom));
      fb.push_back(flaw == FL_ACK ? ack_cfg ^ 8'($urandom_range(255, 1)) : ack_cfg);
      c = CRC_INIT;
      foreach (fb[i]) c = crc_next(c, fb[i]);
      fb.push_back(flaw == FL_CRC_HI ? c[15:8] ^ 8'($urandom_range(255, 1)) : c[15:8]);
      fb.push_back(flaw == FL_CRC_LO ? c[7:0] ^ 8'($urandom_range(255, 1)) : c[7:0]);
    end
    cut = (flaw == FL_ABORT) ? $urandom_range(fb.size() - 1, 0) : fb.size();
    for (int i = 0; i < cut; i++) pending_bytes.push_back('{fb[i], 1'b0});
    if (flaw == FL_ABORT) pending_bytes.push_back('{8'($urandom), 1'b1});
    queued += cut + (flaw == FL_ABORT);
  endtask

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Input driver: predicts on each accepted request, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (track_byte(in_rx_byte, in_abort, pred)) expected_results.push_back(pred);
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
          next_req = pending_bytes.pop_front();
          in_valid   <= 1'b1;
          in_rx_byte <= next_req.rx;
          in_abort   <= next_req.ab;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall: one long hold-off in the pressure phase, random stalls otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (phase_id == PRESSURE_PHASE && !hold_done) begin
      hold_cnt  <= LONG_HOLD;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: kind %0d byte %0h status %0d length %0d",
               out_kind, out_byte, out_frame_status, out_frame_length);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
          mismatches++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          mismatches++;
        end
        if (out_frame_status !== want.status) begin
          $error("frame_status: expected %0d, got %0d", want.status, out_frame_status);
          mismatches++;
        end
        if (out_frame_length !== want.length) begin
          $error("frame_length: expected %0d, got %0d", want.length, out_frame_length);
          mismatches++;
        end
      end
    end
  end

  // Stimulus and phase sequencing
  initial begin
    int unsigned len;
    int          pick;
    flaw_t       flaw;
    logic [7:0]  new_ack;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: abort on an empty frame, shortest good frame, length extremes
    pending_bytes.push_back('{8'h5A, 1'b1});
    queue_frame(3, 1'b0, FL_NONE);
    queue_frame(0, 1'b0, FL_NONE);
    queue_frame(16'hFFFF, 1'b1, FL_NONE);

    for (int p = 1; p <= 8; p++) begin
      // drain before touching the ack register
      while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (p == 8) break;

      case (p)
        1: begin new_ack = 8'h00;          gap_pct = 68; stall_pct = 0;  end
        2: begin new_ack = 8'hFF;          gap_pct = 0;  stall_pct = 68; end
        3: begin new_ack = 8'($urandom);   gap_pct = 15; stall_pct = 15; end
        4: begin new_ack = 8'h01;          gap_pct = 0;  stall_pct = 0;  end
        5: begin new_ack = 8'($urandom);   gap_pct = 68; stall_pct = 0;  end
        6: begin new_ack = 8'hFF;          gap_pct = 0;  stall_pct = 68; end
        default: begin new_ack = 8'h00;    gap_pct = 15; stall_pct = 15; end
      endcase

      // ack register write, then read back
      @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_ACK_VALUE, 2'b00};
      pwdata  <= {24'($urandom), new_ack};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      ack_cfg = new_ack;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata[7:0] !== new_ack) begin
        $error("ack_value readback: expected %0h, got %0h", new_ack, prdata[7:0]);
        mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;

      // Largest accepted length (header passes, frame cut short) and the first past it
      if (p == 6) begin
        pending_bytes.push_back('{8'($urandom_range(255, 1)), 1'b0});
        repeat (3) pending_bytes.push_back('{8'($urandom), 1'b0});
        pending_bytes.push_back('{8'((RFC_MAX_FRAME - HEADER_LEN) >> 8), 1'b0});
        pending_bytes.push_back('{8'(RFC_MAX_FRAME - HEADER_LEN), 1'b0});
        repeat (20) pending_bytes.push_back('{8'($urandom), 1'b0});
        pending_bytes.push_back('{8'($urandom), 1'b1});
        queue_frame(RFC_MAX_FRAME - HEADER_LEN + 1, 1'b0, FL_NONE);
      end

      queued = 0;
      while (queued < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 4)       len = $urandom_range(2, 0);
        else if (pick < 7)  len = $urandom_range(65535, RFC_MAX_FRAME - HEADER_LEN + 1);
        else if (pick < 12) len = $urandom_range(60, 25);
        else                len = $urandom_range(24, 3);
        pick = $urandom_range(99);
        if (pick < 60)      flaw = FL_NONE;
        else if (pick < 70) flaw = FL_CRC_HI;
        else if (pick < 80) flaw = FL_CRC_LO;
        else if (pick < 90) flaw = FL_ACK;
        else                flaw = FL_ABORT;
        queue_frame(len, $urandom_range(19) == 0, flaw);
      end

      // line noise, then an abort to get back in step
      repeat ($urandom_range(16, 4))
        pending_bytes.push_back('{8'($urandom), 1'($urandom_range(3) == 0)});
      pending_bytes.push_back('{8'($urandom), 1'b1});

      phase_id = p;
    end

    gap_pct   = 0;
    stall_pct = 0;
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 400000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
